// ===== design/life_like_ca_generation_step_defines.svh =====
// Assertion macros used by the generation step block.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the synchronous reset is high.
`ifndef LIFE_LIKE_CA_GENERATION_STEP_DEFINES_SVH
`define LIFE_LIKE_CA_GENERATION_STEP_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define LLCA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// When the antecedent holds, the consequent holds at the same edge.
`define LLCA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// When the antecedent holds, the consequent holds at the next edge.
`define LLCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== design/llca_pkg.sv =====
`default_nettype none

package llca_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_BIRTH_MASK   = 2'd0,
      CSR_SURVIVE_MASK = 2'd1,
      CSR_ACTIVE_WIDTH = 2'd2,
      CSR_ACTIVE_HEIGHT = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W  = 11;
   localparam int MASK_W      = 9;
   localparam int SIZE_W      = 11;
   localparam int OUT_COORD_W = 10;

   localparam logic [MASK_W-1:0] BIRTH_MASK_RESET   = 9'd8;
   localparam logic [MASK_W-1:0] SURVIVE_MASK_RESET = 9'd30;
   localparam logic [SIZE_W-1:0] WIDTH_RESET        = 11'd800;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET       = 11'd600;
   localparam logic [SIZE_W-1:0] MIN_SIZE           = 11'd3;

   // One window column: bit 0 is two rows up, bit 1 one row up, bit 2 the current row.
   typedef logic [2:0] col_bits_type;

   // One line buffer entry: bit 1 is two rows up, bit 0 one row up.
   typedef logic [1:0] line_entry_type;

   localparam int WINDOW_COLS = 3;

   typedef struct packed {
      logic                   next_alive;
      logic [OUT_COORD_W-1:0] out_col;
      logic [OUT_COORD_W-1:0] out_row;
      logic                   frame_last;
   } rsp_item_type;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_LEVEL_W    = $clog2(RSP_FIFO_DEPTH + 1);

endpackage

`default_nettype wire

// ===== design/llca_window_cell.sv =====
`default_nettype none

// One column of the 3x3 window; takes its neighbor's column on each shift.
module llca_window_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire llca_pkg::col_bits_type col_in,
   output llca_pkg::col_bits_type      col_q
);
   import llca_pkg::*;

   col_bits_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_q = col_ff;

endmodule

`default_nettype wire

// ===== design/llca_line_buffer.sv =====
`default_nettype none

// Two rows of history in one memory, one read and one write per cycle.
module llca_line_buffer #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output llca_pkg::line_entry_type     rd_data,
   input  wire logic                    wr_en,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire llca_pkg::line_entry_type wr_data
);
   import llca_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/llca_rsp_fifo.sv =====
`default_nettype none

// Small result queue that decouples the pipeline from the result channel.
module llca_rsp_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire llca_pkg::rsp_item_type    push_item,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output llca_pkg::rsp_item_type         rsp_item,
   output logic [llca_pkg::RSP_LEVEL_W-1:0] level_q,
   output logic [llca_pkg::RSP_LEVEL_W-1:0] level_in
);
   import llca_pkg::*;

   rsp_item_type             entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]     wr_ptr_ff;
   logic [RSP_PTR_W-1:0]     rd_ptr_ff;
   logic [RSP_LEVEL_W-1:0]   level_ff;
   logic                     pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign level_q   = level_ff;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + RSP_LEVEL_W'(1);
      end else if (!push && pop) begin
         level_in = level_ff - RSP_LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/life_like_ca_generation_step.sv =====
// One generation of a Life-like cellular automaton with birth and survive masks.
// Cells of the current generation enter on the req_ channel in raster order, one
// bit per transfer; req_frame_start marks the cell at column 0, row 0. For each
// cell at (col,row) with col and row both nonzero, one result transfer on the
// rsp_ channel reports the next state of the cell at (col-1,row-1); the last
// row and column of the grid are never reported, and border cells read dead.
// The csr_ channel writes the birth mask, survive mask, width and height; it is
// always ready and is meant to be written only while the block is idle.
// Throughput is one cell per clock while req_stall is low: the line buffer does
// one read and one write per cycle, and the window cells shift once per cell.
// A result passes the window stage and the rule stage into a small result queue
// that absorbs stalls on rsp_; req_stall comes from a register and rises once
// the queue plus results still in the pipeline could fill it, so nothing is lost
// while rsp_ is stalled. Reset clears the position counters, the window and the
// queue and restores the register defaults (B3/S1234, 800 by 600). Line buffer
// contents are not cleared; stale entries feed only results reported as dead.
`default_nettype none

module life_like_ca_generation_step #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cell_alive,
   input  wire logic                          req_frame_start,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_next_alive,
   output logic [llca_pkg::OUT_COORD_W-1:0]   rsp_out_col,
   output logic [llca_pkg::OUT_COORD_W-1:0]   rsp_out_row,
   output logic                               rsp_frame_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire llca_pkg::csr_index_type       csr_index,
   input  wire logic [llca_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import llca_pkg::*;

`include "life_like_ca_generation_step_defines.svh"

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // Configuration registers.
   logic [MASK_W-1:0] birth_mask_ff;
   logic [MASK_W-1:0] survive_mask_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   // Position counters for the next expected cell.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;

   // Accept stage: position of the incoming cell and its flags.
   logic             accept;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;
   logic             cur_emit;
   logic             cur_calc;
   logic             cur_last;

   // Window stage: line buffer data is back, the window shifts.
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_calc_ff;
   logic             s1_last_ff;
   logic             s1_cur_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             fwd_ff;
   logic             fwd_in;
   line_entry_type   fwd_data_ff;
   line_entry_type   lb_rd_data;
   line_entry_type   lb_entry;
   line_entry_type   lb_wr_data;
   col_bits_type     new_col;

   // Rule stage: the window holds the neighborhood of the reported cell.
   logic             s2_emit_ff;
   logic             s2_calc_ff;
   logic             s2_last_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   col_bits_type     col_chain [WINDOW_COLS+1];
   logic [3*WINDOW_COLS-1:0] window_bits;
   logic [7:0]       nbr_bits;
   logic [3:0]       nbr_count;
   logic [MASK_W-1:0] rule_mask;
   rsp_item_type     push_item;
   rsp_item_type     head_item;

   // Result queue and flow control.
   logic                   req_stall_ff;
   logic                   req_stall_in;
   logic [RSP_LEVEL_W-1:0] fifo_level_q;
   logic [RSP_LEVEL_W-1:0] fifo_level_in;
   logic [RSP_LEVEL_W-1:0] occupancy;
   logic [RSP_LEVEL_W-1:0] occupancy_in;

   // ---------------------------------------------------------------------------
   // Configuration port. Writes always complete in the cycle they are offered.
   // ---------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_mask_ff   <= BIRTH_MASK_RESET;
         survive_mask_ff <= SURVIVE_MASK_RESET;
         width_ff        <= WIDTH_RESET;
         height_ff       <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BIRTH_MASK:    birth_mask_ff   <= csr_wdata[MASK_W-1:0];
            CSR_SURVIVE_MASK:  survive_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_ACTIVE_WIDTH:  width_ff        <= csr_wdata[SIZE_W-1:0];
            CSR_ACTIVE_HEIGHT: height_ff       <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The grid size is clamped to at least three and at most MAX_WIDTH by MAX_HEIGHT.
   // Only the index of the last column and row is needed downstream.
   always_comb begin
      if (width_ff < MIN_SIZE) begin
         w_last = COL_W'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ff - 11'd1);
      end
      if (height_ff < MIN_SIZE) begin
         h_last = ROW_W'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_ff - 11'd1);
      end
   end

   // ---------------------------------------------------------------------------
   // Accept stage. A frame start forces the position to the origin before the
   // cell is taken. The counter wraps when it reaches the last column, which
   // also catches a position left beyond a width that was reduced mid-frame.
   // ---------------------------------------------------------------------------
   assign req_stall = req_stall_ff;
   assign accept    = req_valid && !req_stall;

   assign cur_col  = req_frame_start ? '0 : col_ff;
   assign cur_row  = req_frame_start ? '0 : row_ff;
   assign cur_emit = (cur_col != '0) && (cur_row != '0);
   assign cur_calc = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
   assign cur_last = (cur_col == w_last) && (cur_row == h_last);

   always_comb begin
      col_in = cur_col + COL_W'(1);
      row_in = cur_row;
      if (cur_col >= w_last) begin
         col_in = '0;
         if (cur_row >= h_last) begin
            row_in = '0;
         end else begin
            row_in = cur_row + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The line buffer is read as the cell is taken; the data is registered and
   // used in the window stage, where the same entry is rewritten.
   llca_line_buffer #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (lb_rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (lb_wr_data)
   );

   // If the cell in the window stage writes the entry that is being read for
   // the next cell, the memory returns stale data, so the write is forwarded.
   assign fwd_in = accept && s1_valid_ff && (cur_col == s1_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && cur_emit;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_calc_ff  <= cur_calc;
         s1_last_ff  <= cur_last;
         s1_cur_ff   <= req_cell_alive;
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
         fwd_data_ff <= lb_wr_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Window stage. The incoming column is the row two up, the row one up and
   // the current cell. The buffer entry moves down one row and takes the cell.
   // ---------------------------------------------------------------------------
   assign lb_entry   = fwd_ff ? fwd_data_ff : lb_rd_data;
   assign new_col    = {s1_cur_ff, lb_entry[0], lb_entry[1]};
   assign lb_wr_data = {lb_entry[0], s1_cur_ff};

   // The window is a chain of column cells: the newest column enters the first
   // cell and each cell hands its column to the next one on every shift.
   assign col_chain[0] = new_col;

   for (genvar gi = 0; gi < WINDOW_COLS; gi++) begin : g_window
      llca_window_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_valid_ff),
         .col_in   (col_chain[gi]),
         .col_q    (col_chain[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_calc_ff <= s1_calc_ff;
         s2_last_ff <= s1_last_ff;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Rule stage. The first cell holds the newest column, the second the centre
   // column and the third the oldest. The centre is the middle bit of the
   // centre column; the other eight bits are its neighbors.
   // ---------------------------------------------------------------------------
   assign window_bits = {col_chain[1], col_chain[2], col_chain[3]};
   assign nbr_bits    = {col_chain[1], col_chain[2][2], col_chain[2][0], col_chain[3]};

   always_comb begin
      nbr_count = '0;
      for (int i = 0; i < 8; i++) begin
         nbr_count = nbr_count + {3'b000, nbr_bits[i]};
      end
   end

   assign rule_mask = col_chain[2][1] ? survive_mask_ff : birth_mask_ff;

   // A cell in the first row or column of the grid is a border cell and dies.
   always_comb begin
      push_item.next_alive = s2_calc_ff && rule_mask[nbr_count];
      push_item.out_col    = OUT_COORD_W'(s2_col_ff - COL_W'(1));
      push_item.out_row    = OUT_COORD_W'(s2_row_ff - ROW_W'(1));
      push_item.frame_last = s2_last_ff;
   end

   llca_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_emit_ff),
      .push_item (push_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (head_item),
      .level_q   (fifo_level_q),
      .level_in  (fifo_level_in)
   );

   assign rsp_next_alive = head_item.next_alive;
   assign rsp_out_col    = head_item.out_col;
   assign rsp_out_row    = head_item.out_row;
   assign rsp_frame_last = head_item.frame_last;

   // ---------------------------------------------------------------------------
   // Flow control. Every result still in the pipeline holds a queue slot. The
   // input is stalled when one more accepted cell might not find a slot.
   // ---------------------------------------------------------------------------
   assign occupancy    = fifo_level_q + RSP_LEVEL_W'(s1_emit_ff) + RSP_LEVEL_W'(s2_emit_ff);
   assign occupancy_in = fifo_level_in + RSP_LEVEL_W'(accept && cur_emit)
                       + RSP_LEVEL_W'(s1_emit_ff);
   assign req_stall_in = (occupancy_in >= RSP_LEVEL_W'(RSP_FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         req_stall_ff <= 1'b0;
      end else begin
         req_stall_ff <= req_stall_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------
   // Results in flight never exceed the queue, so no result is dropped.
   `LLCA_ASSERT_ALWAYS(a_credit_bound, clock, reset, occupancy <= RSP_LEVEL_W'(RSP_FIFO_DEPTH))
   // Only cells off the first row and column produce a result.
   `LLCA_ASSERT_IMPLIES(a_emit_position, clock, reset, s2_emit_ff, (s2_col_ff != '0) && (s2_row_ff != '0))
   // The window moves only when a cell passes the window stage.
   `LLCA_ASSERT_NEXT(a_window_hold, clock, reset, !s1_valid_ff, $stable(window_bits))

endmodule

`default_nettype wire
